// File: hdl/rfp_pkg.sv
// Shared definitions for the radix-64 field packer: action codes, size constants
// and the character/symbol conversion and divide-by-six helpers.
// No dependencies.
package rfp_pkg;

    localparam int DEF_STORE_DEPTH     = 512;
    localparam int DEF_MAX_FIELD_WIDTH = 16;
    localparam int FIELD_W_CAP         = 16;
    localparam int SYM_W               = 6;

    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_FLUSH = 3'd1,
        ACT_LOAD  = 3'd2,
        ACT_READ  = 3'd3,
        ACT_NEW   = 3'd4
    } t_action;

    // 6-bit symbol to alphabet character: 0-9, A-Z, a-z, '-', '_'
    function automatic logic [7:0] sym2char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd10) begin
            c = 8'd48 + {2'b00, s};
        end else if (s < 6'd36) begin
            c = 8'd55 + {2'b00, s};
        end else if (s < 6'd62) begin
            c = 8'd61 + {2'b00, s};
        end else if (s == 6'd62) begin
            c = 8'd45;
        end else begin
            c = 8'd95;
        end
        return c;
    endfunction

    // Alphabet character to symbol; anything outside the alphabet maps to 0
    function automatic logic [5:0] char2sym(input logic [7:0] c);
        logic [7:0] s;
        if (c >= 8'd48 && c <= 8'd57) begin
            s = c - 8'd48;
        end else if (c >= 8'd65 && c <= 8'd90) begin
            s = c - 8'd55;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            s = c - 8'd61;
        end else if (c == 8'd45) begin
            s = 8'd62;
        end else if (c == 8'd95) begin
            s = 8'd63;
        end else begin
            s = 8'd0;
        end
        return s[5:0];
    endfunction

    // Split a bit count below 24 into whole groups of six and the remainder:
    // result is {quotient[1:0], remainder[2:0]}
    function automatic logic [4:0] divmod6(input logic [4:0] t);
        logic [1:0] q;
        logic [4:0] r;
        if (t < 5'd6) begin
            q = 2'd0;
            r = t;
        end else if (t < 5'd12) begin
            q = 2'd1;
            r = t - 5'd6;
        end else if (t < 5'd18) begin
            q = 2'd2;
            r = t - 5'd12;
        end else begin
            q = 2'd3;
            r = t - 5'd18;
        end
        return {q, r[2:0]};
    endfunction

endpackage

// File: hdl/rfp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rfp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/radix64_field_packer.sv
// Radix-64 field packer: top level with the writer, the symbol-store reader and
// the result queue. Depends on rfp_pkg and rfp_ram.
//
// Usage:
//   Slave channel (s_axis) carries one command per transaction; tuser holds the
//   action (write field, flush, load character, read field, new message).
//   Master channel (m_axis) returns results: encoded characters (tuser = 0) or
//   decoded field values (tuser = 1). tlast marks the final result of a command.
//   Write, flush, load and new-message commands never leave the idle state, so
//   they can be accepted on consecutive cycles while the queue is not full. A
//   write yields up to three characters, delivered one per cycle from the
//   result queue while the receiver is ready. A read command makes four symbol
//   fetches from the store RAM (registered read), then assembles the field; its
//   result enters the queue and is visible in the cycle after it is pushed.
//   The result queue holds four commands' worth of results; when the receiver
//   stalls, commands keep being accepted until the queue is full.
//   Reset clears all counters, positions, the group accumulator, the overflow
//   flag and the queue. Store contents are not cleared; only entries below the
//   load count are ever used.
module radix64_field_packer
    import rfp_pkg::*;
#(
    parameter int STORE_DEPTH     = DEF_STORE_DEPTH,
    parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [16:0] field_value, [21:17] field_width, [29:22] in_char, [31:30] zero
    input  logic [31:0] i_s_axis_tdata,
    // [2:0] action
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_char, [24:8] out_value, [25] overflow, [31:26] zero
    output logic [31:0] o_m_axis_tdata,
    // [0] out_kind
    output logic [0:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int WLIM = (MAX_FIELD_WIDTH > FIELD_W_CAP) ? FIELD_W_CAP : MAX_FIELD_WIDTH;
    localparam int QD   = 4;
    localparam int QPW  = $clog2(QD);

    typedef enum logic {S_IDLE, S_READ} t_state;

    typedef struct packed {
        logic                   kind;
        logic [1:0]             cnt;
        logic [2:0][7:0]        chars;
        logic signed [16:0]     value;
        logic                   ovf;
    } t_bundle;

    // input transaction fields
    t_action            in_action;
    logic signed [16:0] in_value;
    logic [4:0]         in_width;
    logic [7:0]         in_char;
    logic [4:0]         w_eff;
    logic               acc_in;

    // state
    t_state         r_state;
    logic [CW-1:0]  r_load_cnt;
    logic [CW-1:0]  r_rd_pos;
    logic [2:0]     r_rd_bit;
    logic [5:0]     r_acc;
    logic [2:0]     r_wbc;
    logic           r_ovf;
    logic [2:0]     r_k;
    logic [4:0]     r_rw;
    logic [17:0]    r_win;

    // store
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [5:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [5:0]     ram_rdata;

    // writer
    logic            wsign;
    logic [16:0]     wmag17;
    logic [15:0]     wmagm;
    logic [21:0]     wx;
    logic [4:0]      wt;
    logic [4:0]      wdm;
    logic [1:0]      wq;
    logic [2:0]      wr;
    logic [5:0]      wacc_new;
    logic [2:0][7:0] wchars;
    logic [7:0]      fchar;

    // reader
    logic [CW-1:0]      diff;
    logic [2:0]         dc;
    logic [4:0]         avail;
    logic [4:0]         need;
    logic [23:0]        win;
    logic [23:0]        mb;
    logic               rd_sign;
    logic [15:0]        rd_mag;
    logic signed [16:0] rd_val;
    logic               rd_short;
    logic [4:0]         rd_dm;
    logic               rd_done;

    // result queue
    t_bundle          r_q [QD];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QPW:0]     r_qcnt;
    logic [1:0]       r_sub;
    t_bundle          head;
    t_bundle          nb;
    logic             push;
    logic             pop;
    logic             out_last;

    assign in_action = t_action'(i_s_axis_tuser);
    assign in_value  = i_s_axis_tdata[16:0];
    assign in_width  = i_s_axis_tdata[21:17];
    assign in_char   = i_s_axis_tdata[29:22];
    assign w_eff     = (in_width > 5'(WLIM)) ? 5'(WLIM) : in_width;

    assign o_s_axis_tready = (r_state == S_IDLE) && (r_qcnt != (QPW+1)'(QD));
    assign acc_in          = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- symbol store ----------------
    assign ram_we    = acc_in && (in_action == ACT_LOAD)
                       && (r_load_cnt != CW'(STORE_DEPTH));
    assign ram_waddr = r_load_cnt[AW-1:0];
    assign ram_wdata = char2sym(in_char);
    // r_k is zero while idle, so the accept cycle fetches the current symbol
    assign ram_raddr = r_rd_pos[AW-1:0] + AW'(r_k);

    rfp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- writer ----------------
    always_comb begin
        wsign    = in_value[16];
        wmag17   = wsign ? (17'd0 - in_value) : in_value;
        wmagm    = wmag17[15:0] & ~(16'hFFFF << w_eff);
        wx       = (22'(r_acc) << (w_eff + 5'd1)) | (22'(wsign) << w_eff) | 22'(wmagm);
        wt       = 5'(r_wbc) + w_eff + 5'd1;
        wdm      = divmod6(wt);
        wq       = wdm[4:3];
        wr       = wdm[2:0];
        wacc_new = 6'(wx) & ((6'd1 << wr) - 6'd1);
        for (int i = 0; i < 3; i++) begin
            wchars[i] = sym2char(6'(wx >> (wt - 5'(6 * (i + 1)))));
        end
        // pad the partial group with zeros
        fchar = sym2char(r_acc << (3'd6 - r_wbc));
    end

    // ---------------- reader ----------------
    always_comb begin
        diff     = r_load_cnt - r_rd_pos;
        dc       = (diff > CW'(4)) ? 3'd4 : diff[2:0];
        avail    = 5'({2'b00, dc} * 5'd6) - 5'(r_rd_bit);
        need     = r_rw + 5'd1;
        win      = {r_win, ram_rdata};
        // zero every bit past the loaded data
        mb       = (win << r_rd_bit) & ~(24'hFF_FFFF >> avail);
        rd_sign  = mb[23];
        rd_mag   = 16'(mb[22:0] >> (5'd23 - r_rw));
        rd_val   = rd_sign ? (17'd0 - {1'b0, rd_mag}) : {1'b0, rd_mag};
        rd_short = avail < need;
        rd_dm    = divmod6(5'(r_rd_bit) + need);
        rd_done  = (r_state == S_READ) && (r_k == 3'd4);
    end

    // ---------------- result bundle ----------------
    always_comb begin
        push = 1'b0;
        nb   = '0;
        if (acc_in) begin
            unique case (in_action)
                ACT_WRITE: begin
                    push     = (wq != 2'd0);
                    nb.cnt   = wq;
                    nb.chars = wchars;
                    nb.ovf   = r_ovf;
                end
                ACT_FLUSH: begin
                    push        = (r_wbc != 3'd0);
                    nb.cnt      = 2'd1;
                    nb.chars[0] = fchar;
                    nb.ovf      = r_ovf;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end else if (rd_done) begin
            push     = 1'b1;
            nb.kind  = 1'b1;
            nb.cnt   = 2'd1;
            nb.value = rd_val;
            nb.ovf   = r_ovf | rd_short;
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_cnt <= '0;
            r_rd_pos   <= '0;
            r_rd_bit   <= '0;
            r_acc      <= '0;
            r_wbc      <= '0;
            r_ovf      <= 1'b0;
            r_k        <= '0;
            r_rw       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        unique case (in_action)
                            ACT_WRITE: begin
                                r_acc <= wacc_new;
                                r_wbc <= wr;
                            end
                            ACT_FLUSH: begin
                                r_acc <= '0;
                                r_wbc <= '0;
                            end
                            ACT_LOAD: begin
                                if (r_load_cnt == CW'(STORE_DEPTH)) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_load_cnt <= r_load_cnt + CW'(1);
                                end
                            end
                            ACT_READ: begin
                                r_state <= S_READ;
                                r_k     <= 3'd1;
                                r_rw    <= w_eff;
                            end
                            ACT_NEW: begin
                                r_load_cnt <= '0;
                                r_rd_pos   <= '0;
                                r_rd_bit   <= '0;
                                r_acc      <= '0;
                                r_wbc      <= '0;
                                r_ovf      <= 1'b0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (r_k == 3'd4) begin
                        r_state <= S_IDLE;
                        r_k     <= '0;
                        if (rd_short) begin
                            // consumed everything that was loaded
                            r_rd_pos <= r_load_cnt;
                            r_rd_bit <= '0;
                            r_ovf    <= 1'b1;
                        end else begin
                            r_rd_pos <= r_rd_pos + CW'(rd_dm[4:3]);
                            r_rd_bit <= rd_dm[2:0];
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // collect fetched symbols, oldest in the top bits
    always_ff @(posedge i_clk) begin
        r_win <= {r_win[11:0], ram_rdata};
    end

    // ---------------- result queue ----------------
    assign head     = r_q[r_rp];
    assign out_last = (r_sub == (head.cnt - 2'd1));
    assign pop      = o_m_axis_tvalid && i_m_axis_tready && out_last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
            r_sub  <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (out_last) begin
                    r_rp  <= r_rp + QPW'(1);
                    r_sub <= '0;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
            r_qcnt <= r_qcnt + (QPW+1)'(push) - (QPW+1)'(pop);
        end
    end

    assign o_m_axis_tvalid   = (r_qcnt != '0);
    assign o_m_axis_tuser[0] = head.kind;
    assign o_m_axis_tlast    = out_last;
    assign o_m_axis_tdata    = {6'd0, head.ovf,
                                head.kind ? head.value : 17'd0,
                                head.kind ? 8'd0 : head.chars[r_sub]};

endmodule

// File: test/tb_radix64_field_packer.sv
// Self-checking testbench for radix64_field_packer: directed command table plus
// random messages, checked against a local model of the packer and unpacker.
// Depends on rfp_pkg and the packer RTL.
module tb_radix64_field_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam int ITEM_TARGET = 220;
    localparam int WIDTH_LIMIT = (DEF_MAX_FIELD_WIDTH < FIELD_W_CAP) ?
                                 DEF_MAX_FIELD_WIDTH : FIELD_W_CAP;
    localparam logic [8*64-1:0] ALPHABET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_";

    typedef struct packed {
        logic        kind;
        logic [7:0]  chr;
        logic [16:0] val;
        logic        ovf;
        logic        last;
    } t_pk_result;

    typedef struct {
        logic [2:0]  act;
        logic [16:0] val;
        logic [4:0]  wid;
        logic [7:0]  chr;
        bit          typed;
        t_pk_result  res;
    } t_cmd_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic [31:0] cmd_data = '0;
    logic [2:0]  cmd_user = '0;
    logic        result_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Packer model state
    logic [5:0]  sym_store [DEF_STORE_DEPTH];
    int unsigned loaded_syms = 0;
    int unsigned rd_pos = 0;
    int unsigned rd_bit = 0;
    int unsigned wr_bits = 0;
    logic [5:0]  wr_acc = '0;
    bit          ovf_sticky = 1'b0;

    t_pk_result  step_results[$];
    t_pk_result  expected_results[$];
    t_cmd_row    directed_rows[$];

    int sender_idle_pct = 33;
    int recv_stall_pct = 75;
    int cmds_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;

    radix64_field_packer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (cmd_data),
        .i_s_axis_tuser  (cmd_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (result_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] char_of_sym(logic [5:0] s);
        return ALPHABET[8*(63 - s) +: 8];
    endfunction

    function automatic logic [5:0] sym_of_char(logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (char_of_sym(k[5:0]) == c) begin
                return k[5:0];
            end
        end
        return '0;
    endfunction

    function automatic void shift_into_group(bit b);
        wr_acc = {wr_acc[4:0], b};
        wr_bits++;
        if (wr_bits == 6) begin
            step_results.insert(step_results.size(),
                                '{1'b0, char_of_sym(wr_acc), 17'd0, 1'b0, 1'b0});
            wr_acc = '0;
            wr_bits = 0;
        end
    endfunction

    // Past the loaded symbols: return zero, flag overflow, hold the position
    function automatic bit take_stored_bit();
        bit b;
        if (rd_pos >= loaded_syms || rd_pos >= DEF_STORE_DEPTH) begin
            ovf_sticky = 1'b1;
            return 1'b0;
        end
        b = sym_store[rd_pos][5 - rd_bit];
        rd_bit++;
        if (rd_bit == 6) begin
            rd_bit = 0;
            rd_pos++;
        end
        return b;
    endfunction

    function automatic void pack_unpack_step(logic [2:0] act, logic [16:0] raw,
                                             logic [4:0] wid, logic [7:0] chr);
        int unsigned w;
        bit          sign;
        logic [16:0] mag;
        logic [16:0] field;
        w = (wid > WIDTH_LIMIT) ? WIDTH_LIMIT : wid;
        step_results.delete();
        case (act)
            ACT_WRITE: begin
                sign = raw[16];
                mag = sign ? 17'd0 - raw : raw;
                shift_into_group(sign);
                for (int i = w; i > 0; i--) begin
                    shift_into_group(mag[i-1]);
                end
            end
            ACT_FLUSH: begin
                while (wr_bits != 0) begin
                    shift_into_group(1'b0);
                end
            end
            ACT_LOAD: begin
                if (loaded_syms >= DEF_STORE_DEPTH) begin
                    ovf_sticky = 1'b1;
                end else begin
                    sym_store[loaded_syms] = sym_of_char(chr);
                    loaded_syms++;
                end
            end
            ACT_READ: begin
                sign = take_stored_bit();
                mag = '0;
                for (int i = 0; i < w; i++) begin
                    mag = {mag[15:0], take_stored_bit()};
                end
                field = sign ? 17'd0 - mag : mag;
                step_results.insert(step_results.size(), '{1'b1, 8'd0, field, 1'b0, 1'b0});
            end
            ACT_NEW: begin
                loaded_syms = 0;
                rd_pos = 0;
                rd_bit = 0;
                wr_acc = '0;
                wr_bits = 0;
                ovf_sticky = 1'b0;
            end
            default: ;
        endcase
        foreach (step_results[k]) begin
            step_results[k].ovf = ovf_sticky;
            step_results[k].last = (k == step_results.size() - 1);
        end
    endfunction

    function automatic void add_row(logic [2:0] act, logic [16:0] val, logic [4:0] wid,
                                    logic [7:0] chr, bit typed = 1'b0,
                                    t_pk_result res = '0);
        directed_rows.insert(directed_rows.size(), '{act, val, wid, chr, typed, res});
    endfunction

    function automatic logic [16:0] rand_value();
        logic [16:0] v;
        // -65536 lies outside the field range
        do begin
            v = 17'($urandom_range(0, 17'h1FFFF));
        end while (v == 17'h10000);
        return v;
    endfunction

    function automatic logic [4:0] rand_width();
        if ($urandom_range(0, 99) < 85) begin
            return 5'($urandom_range(0, 16));
        end
        return 5'($urandom_range(17, 31));
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return char_of_sym(6'($urandom_range(0, 63)));
    endfunction

    task automatic send_cmd(logic [2:0] act, logic [16:0] val, logic [4:0] wid,
                            logic [7:0] chr, bit typed = 1'b0, t_pk_result res = '0);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= {2'b00, chr, wid, val};
        cmd_user <= act;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        pack_unpack_step(act, val, wid, chr);
        if (typed) begin
            expected_results.insert(expected_results.size(), res);
        end else begin
            foreach (step_results[k]) begin
                expected_results.insert(expected_results.size(), step_results[k]);
            end
        end
        cmds_sent++;
    endtask

    // Well-formed message: fresh start, some writes, loads, then reads that
    // consume the loaded bits, the last one often running past them
    task automatic run_message();
        int n_wr;
        int n_ld;
        int bits_left;
        logic [4:0] w;
        send_cmd(ACT_NEW, rand_value(), 5'($urandom_range(0, 31)),
                 8'($urandom_range(0, 255)));
        n_wr = $urandom_range(0, 5);
        repeat (n_wr) send_cmd(ACT_WRITE, rand_value(), rand_width(),
                               8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) begin
            send_cmd(ACT_FLUSH, rand_value(), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)));
        end
        n_ld = $urandom_range(1, 12);
        repeat (n_ld) send_cmd(ACT_LOAD, rand_value(), 5'($urandom_range(0, 31)), rand_char());
        bits_left = n_ld * 6;
        while (bits_left > 0) begin
            w = rand_width();
            send_cmd(ACT_READ, rand_value(), w, 8'($urandom_range(0, 255)));
            bits_left -= ((w > WIDTH_LIMIT) ? WIDTH_LIMIT : w) + 1;
        end
    endtask

    initial begin
        for (int k = 0; k < DEF_STORE_DEPTH; k++) sym_store[k] = '0;

        // Read at reset runs past empty data
        add_row(ACT_READ, 17'h0, 5'd0, 8'h00, 1'b1, '{1'b1, 8'h00, 17'h0, 1'b1, 1'b1});
        add_row(ACT_NEW, 17'h0, 5'd0, 8'h00);
        add_row(ACT_WRITE, 17'h0, 5'd5, 8'h00, 1'b1, '{1'b0, "0", 17'h0, 1'b0, 1'b1});
        add_row(ACT_WRITE, 17'h0FFFF, 5'd16, 8'h00);
        add_row(ACT_FLUSH, 17'h0, 5'd0, 8'h00);
        add_row(ACT_FLUSH, 17'h0, 5'd0, 8'h00);
        add_row(ACT_WRITE, 17'h10001, 5'd16, 8'h00);
        // Oversized width saturates
        add_row(ACT_WRITE, 17'h1FFFF, 5'd31, 8'h00);
        add_row(ACT_WRITE, 17'h00001, 5'd0, 8'h00);
        add_row(ACT_FLUSH, 17'h0, 5'd0, 8'h00);
        add_row(ACT_LOAD, 17'h0, 5'd0, "0");
        add_row(ACT_LOAD, 17'h0, 5'd0, "Z");
        add_row(ACT_LOAD, 17'h0, 5'd0, "z");
        add_row(ACT_LOAD, 17'h0, 5'd0, "-");
        add_row(ACT_LOAD, 17'h0, 5'd0, "_");
        // Unknown character decodes to symbol zero
        add_row(ACT_LOAD, 17'h0, 5'd0, 8'hFF);
        add_row(ACT_READ, 17'h0, 5'd16, 8'h00);
        add_row(ACT_READ, 17'h0, 5'd31, 8'h00);
        // Sign set with zero magnitude reads back as plain zero
        add_row(ACT_NEW, 17'h0, 5'd0, 8'h00);
        add_row(ACT_LOAD, 17'h0, 5'd0, "W");
        add_row(ACT_READ, 17'h0, 5'd5, 8'h00, 1'b1, '{1'b1, 8'h00, 17'h0, 1'b0, 1'b1});
        add_row(ACT_READ, 17'h0, 5'd2, 8'h00, 1'b1, '{1'b1, 8'h00, 17'h0, 1'b1, 1'b1});
        add_row(ACT_SPARE_A, 17'h1FFFF, 5'h1F, 8'hFF);
        add_row(ACT_SPARE_B, 17'h0AAAA, 5'h15, 8'hAA);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].act, directed_rows[k].val, directed_rows[k].wid,
                     directed_rows[k].chr, directed_rows[k].typed, directed_rows[k].res);
        end

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 75 : 0;
            recv_stall_pct  = (phase == 0) ? 75 : (phase == 1) ? 33 : 0;
            while (cmds_sent < ITEM_TARGET * (phase + 1) / 3) begin
                if ($urandom_range(0, 9) < 8) begin
                    run_message();
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_cmd(3'($urandom_range(0, 7)), rand_value(),
                                 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
                    end
                end
            end
        end
        cmd_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d commands: directed table, then random messages under three stall mixes",
                 cmds_sent);
        $display("Checked %0d results (characters and decoded fields)", results_checked);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_pk_result got;
        t_pk_result want;
        if (i_rst_n && o_m_axis_tvalid && result_ready) begin
            got = '{o_m_axis_tuser[0], o_m_axis_tdata[7:0], o_m_axis_tdata[24:8],
                    o_m_axis_tdata[25], o_m_axis_tlast};
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result kind=%0d char=%h value=%h ovf=%0d last=%0d",
                         $realtime, got.kind, got.chr, got.val, got.ovf, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: expected kind=%0d char=%h value=%h ovf=%0d last=%0d",
                             $realtime, want.kind, want.chr, want.val, want.ovf, want.last);
                    $display("%0t:   actual kind=%0d char=%h value=%h ovf=%0d last=%0d",
                             $realtime, got.kind, got.chr, got.val, got.ovf, got.last);
                end
            end
        end
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
